[rtl/core/rsb_pkg.sv]
// Shared constants and beat layouts for the run-length sprite clip blitter.
`timescale 1ns / 1ps

package rsb_pkg;

    // Input beat kinds carried on s_tuser
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_STREAM = 1'b1;

    // Payload widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Column counter: 12-bit signed, saturating at the top
    localparam int COL_W = 12;
    localparam logic signed [COL_W-1:0] COL_MAX     = 12'sd2047;
    localparam logic signed [COL_W:0]   COL_SUM_MAX = 13'sd2047;

    // Nibble masks for the transparency test
    localparam logic [7:0] LO_NIBBLE_MASK = 8'h0F;
    localparam logic [7:0] HI_NIBBLE_MASK = 8'hF0;

    // One result beat
    typedef struct packed {
        logic       write_valid;
        logic [7:0] out_row;
        logic [6:0] out_column;
        logic [7:0] out_byte;
        logic [1:0] nibble_enable;
        logic       done_res;
    } result_t;

endpackage

[rtl/core/rle_sprite_clip_blitter_unit.sv]
// Top level of the run-length sprite clip blitter: stream parser and result register.
`timescale 1ns / 1ps

// A result beat is registered and appears on the master side in the cycle after the input beat that causes it.
// Throughput: one input beat per cycle while s_tready is high; the parse registers and the
//   column counter are all updated together from the accepted beat.
// A waiting result never blocks the input while the master side accepts it that cycle.
// Reset (rst_n low, asynchronous): parser goes idle, counters clear, no result pending.
module rle_sprite_clip_blitter_unit
    import rsb_pkg::*;
#(
    parameter int BYTES_PER_ROW = 80
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, from bit 0: start_x[8:0], start_row[7:0], row_count[7:0],
    //   stream_byte[7:0], zero pad[6:0]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser, from bit 0: kind
    input  logic [0:0]           s_tuser,
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, from bit 0: out_row[7:0], out_column[6:0], out_byte[7:0],
    //   nibble_enable[1:0], zero pad[6:0]
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser, from bit 0: write_valid
    output logic [0:0]           m_tuser,
    // m_tlast: done_res, end of the sprite
    output logic                 m_tlast
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SKIP = 2'd1,
        PH_RUN  = 2'd2,
        PH_LIT  = 2'd3
    } phase_t;

    // Parser state
    phase_t                   phase_reg,            phase_next;
    logic [7:0]               pending_skip_reg,     pending_skip_next;
    logic [7:0]               run_left_reg,         run_left_next;
    logic signed [COL_W-1:0]  column_reg,           column_next;
    logic signed [COL_W-1:0]  row_start_column_reg, row_start_column_next;
    logic [7:0]               current_row_reg,      current_row_next;
    logic [7:0]               rows_left_reg,        rows_left_next;

    // Result register
    logic                     out_valid_reg,        out_valid_next;
    result_t                  result_reg,           result_next;

    // Input beat fields
    logic                     kind;
    logic signed [8:0]        start_x;
    logic [7:0]               start_row;
    logic [7:0]               row_count;
    logic [7:0]               stream_byte;
    logic                     in_beat;

    // Column arithmetic
    logic signed [COL_W:0]    skip_sum;
    logic signed [COL_W:0]    inc_sum;
    logic signed [COL_W-1:0]  col_after_skip;
    logic signed [COL_W-1:0]  col_after_inc;
    logic                     col_on_screen;
    logic [7:0]               run_dec;
    logic [7:0]               rows_dec;

    assign kind        = s_tuser[0];
    assign start_x     = $signed(s_tdata[8:0]);
    assign start_row   = s_tdata[16:9];
    assign row_count   = s_tdata[24:17];
    assign stream_byte = s_tdata[32:25];

    // Take a beat whenever the result slot is empty or drains this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;

    // Saturating column adds: skip and single-step advance
    assign skip_sum = $signed({column_reg[COL_W-1], column_reg})
                    + $signed({5'b0, pending_skip_reg});
    assign inc_sum  = $signed({column_reg[COL_W-1], column_reg}) + 13'sd1;
    assign col_after_skip = (skip_sum > COL_SUM_MAX) ? COL_MAX : skip_sum[COL_W-1:0];
    assign col_after_inc  = (inc_sum  > COL_SUM_MAX) ? COL_MAX : inc_sum[COL_W-1:0];

    // Visible only in byte columns 0 .. BYTES_PER_ROW-1
    assign col_on_screen = !column_reg[COL_W-1]
                        && (column_reg < COL_W'(BYTES_PER_ROW));

    assign run_dec  = run_left_reg - 8'd1;
    assign rows_dec = rows_left_reg - 8'd1;

    always_comb
    begin
        phase_next            = phase_reg;
        pending_skip_next     = pending_skip_reg;
        run_left_next         = run_left_reg;
        column_next           = column_reg;
        row_start_column_next = row_start_column_reg;
        current_row_next      = current_row_reg;
        rows_left_next        = rows_left_reg;
        result_next           = result_reg;
        out_valid_next        = out_valid_reg && !m_tready;

        if (in_beat)
        begin
            // Each accepted beat replaces the (drained) result slot
            out_valid_next = 1'b0;
            result_next    = '0;

            if (kind == KIND_START)
            begin
                // Floor-halve the pixel x to a byte column; abort any sprite in flight
                row_start_column_next = {{(COL_W-8){start_x[8]}}, start_x[8:1]};
                column_next           = {{(COL_W-8){start_x[8]}}, start_x[8:1]};
                current_row_next      = start_row;
                rows_left_next        = row_count;
                pending_skip_next     = 8'd0;
                run_left_next         = 8'd0;
                if (row_count == 8'd0)
                begin
                    phase_next           = PH_IDLE;
                    out_valid_next       = 1'b1;
                    result_next.done_res = 1'b1;
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        // Drop stray stream bytes
                    end
                    PH_SKIP:
                    begin
                        pending_skip_next = stream_byte;
                        phase_next        = PH_RUN;
                    end
                    PH_RUN:
                    begin
                        if (pending_skip_reg == 8'd0 && stream_byte == 8'd0)
                        begin
                            // End of row: advance row, rewind column
                            rows_left_next   = rows_dec;
                            current_row_next = current_row_reg + 8'd1;
                            column_next      = row_start_column_reg;
                            if (rows_dec == 8'd0)
                            begin
                                phase_next           = PH_IDLE;
                                out_valid_next       = 1'b1;
                                result_next.done_res = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                        else
                        begin
                            column_next   = col_after_skip;
                            run_left_next = stream_byte;
                            phase_next    = (stream_byte == 8'd0) ? PH_SKIP : PH_LIT;
                        end
                    end
                    PH_LIT:
                    begin
                        run_left_next = run_dec;
                        if (col_on_screen && stream_byte != 8'd0)
                        begin
                            out_valid_next              = 1'b1;
                            result_next.write_valid     = 1'b1;
                            result_next.out_row         = current_row_reg;
                            result_next.out_column      = column_reg[6:0];
                            result_next.out_byte        = stream_byte;
                            result_next.nibble_enable[1] =
                                (stream_byte & HI_NIBBLE_MASK) != 8'd0;
                            result_next.nibble_enable[0] =
                                (stream_byte & LO_NIBBLE_MASK) != 8'd0;
                        end
                        // Clipped bytes still advance the column
                        column_next = col_after_inc;
                        if (run_dec == 8'd0)
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            pending_skip_reg     <= 8'd0;
            run_left_reg         <= 8'd0;
            column_reg           <= '0;
            row_start_column_reg <= '0;
            current_row_reg      <= 8'd0;
            rows_left_reg        <= 8'd0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            phase_reg            <= phase_next;
            pending_skip_reg     <= pending_skip_next;
            run_left_reg         <= run_left_next;
            column_reg           <= column_next;
            row_start_column_reg <= row_start_column_next;
            current_row_reg      <= current_row_next;
            rows_left_reg        <= rows_left_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {7'b0, result_reg.nibble_enable, result_reg.out_byte,
                         result_reg.out_column, result_reg.out_row};
    assign m_tuser[0] = result_reg.write_valid;
    assign m_tlast    = result_reg.done_res;

    // A done beat is never also a write
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.done_res |-> !result_reg.write_valid)
        else $error("done beat flagged as write");

    // A write beat always enables at least one nibble
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.write_valid |-> result_reg.nibble_enable != 2'b00)
        else $error("write beat with no nibble enabled");

    // The column counter never passes its saturation point
    assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= COL_MAX)
        else $error("column counter above saturation");

    // A done result leaves the parser idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && out_valid_next && result_next.done_res |=> phase_reg == PH_IDLE)
        else $error("parser not idle after done");

endmodule

[test/testbench.sv]
// Self-checking testbench for the run-length sprite clip blitter: stream stimulus, predictor, checker.
`timescale 1ns / 1ps

module testbench;
    import rsb_pkg::*;

    localparam int BYTES_PER_ROW = 80;
    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 8;
    localparam int STALL_PCT     = 10;
    localparam int TARGET_ITEMS  = 600;
    localparam int STALL_LIMIT   = 1000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES  = 8;
    localparam int PRINT_CAP     = 40;

    // Decoder phase as the predictor tracks it
    typedef enum logic [1:0] {
        P_IDLE,
        P_WANT_SKIP,
        P_WANT_RUN,
        P_IN_LITS
    } parse_phase_t;

    // One input beat before packing
    typedef struct {
        logic       kind;
        logic [8:0] start_x;
        logic [7:0] start_row;
        logic [7:0] row_count;
        logic [7:0] stream_byte;
    } blit_item_t;

    // DUT connections; every input starts at a known value
    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    // Stimulus waiting for the driver, and writes/done marks the block still owes us
    blit_item_t item_q[$];
    result_t    fb_expect_q[$];
    int         stim_count  = 0;
    int         error_count = 0;
    int         cycle_count = 0;
    int         quiet_count = 0;
    blit_item_t on_bus;

    // Predictor copy of the decoder state
    parse_phase_t               parse_st    = P_IDLE;
    logic [7:0]                 skip_held   = '0;
    logic [7:0]                 lits_left   = '0;
    logic signed [COL_W-1:0]    cursor      = '0;
    logic signed [COL_W-1:0]    line_origin = '0;
    logic [7:0]                 cur_row     = '0;
    logic [7:0]                 rows_to_go  = '0;

    rle_sprite_clip_blitter_unit #(
        .BYTES_PER_ROW(BYTES_PER_ROW)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Advance the column, saturating at the top of the 12-bit signed range
    function automatic logic signed [COL_W-1:0] col_advance(logic signed [COL_W-1:0] c,
                                                            logic [7:0] d);
        logic signed [COL_W:0] sum;
        sum = c + $signed({5'b0, d});
        return (sum > COL_SUM_MAX) ? COL_MAX : sum[COL_W-1:0];
    endfunction

    // Update the decoder state with one accepted beat; queue the write or done it causes
    task automatic decode_sprite_beat(input blit_item_t it);
        result_t r;
        logic [7:0] b;
        r = '0;
        b = it.stream_byte;
        if (it.kind == KIND_START)
        begin
            // Floor-halve the pixel x: arithmetic shift of the signed 9-bit value
            line_origin = {{(COL_W - 8){it.start_x[8]}}, it.start_x[8:1]};
            cursor      = line_origin;
            cur_row     = it.start_row;
            rows_to_go  = it.row_count;
            skip_held   = '0;
            lits_left   = '0;
            if (rows_to_go == 8'd0)
            begin
                parse_st   = P_IDLE;
                r.done_res = 1'b1;
                fb_expect_q.push_back(r);
            end
            else
            begin
                parse_st = P_WANT_SKIP;
            end
        end
        else
        begin
            case (parse_st)
                P_WANT_SKIP:
                begin
                    skip_held = b;
                    parse_st  = P_WANT_RUN;
                end
                P_WANT_RUN:
                begin
                    if (skip_held == 8'd0 && b == 8'd0)
                    begin
                        // End of row: step the row (wraps) and rewind the column
                        rows_to_go = rows_to_go - 8'd1;
                        cur_row    = cur_row + 8'd1;
                        cursor     = line_origin;
                        if (rows_to_go == 8'd0)
                        begin
                            parse_st   = P_IDLE;
                            r.done_res = 1'b1;
                            fb_expect_q.push_back(r);
                        end
                        else
                        begin
                            parse_st = P_WANT_SKIP;
                        end
                    end
                    else
                    begin
                        cursor    = col_advance(cursor, skip_held);
                        lits_left = b;
                        parse_st  = (b == 8'd0) ? P_WANT_SKIP : P_IN_LITS;
                    end
                end
                P_IN_LITS:
                begin
                    lits_left = lits_left - 8'd1;
                    // Drop clipped columns and fully transparent bytes
                    if (cursor >= 0 && cursor < BYTES_PER_ROW && b != 8'd0)
                    begin
                        r.write_valid   = 1'b1;
                        r.out_row       = cur_row;
                        r.out_column    = cursor[6:0];
                        r.out_byte      = b;
                        r.nibble_enable = {(b & HI_NIBBLE_MASK) != 8'd0,
                                           (b & LO_NIBBLE_MASK) != 8'd0};
                        fb_expect_q.push_back(r);
                    end
                    cursor = col_advance(cursor, 8'd1);
                    if (lits_left == 8'd0)
                    begin
                        parse_st = P_WANT_SKIP;
                    end
                end
                default:
                begin
                    // Idle: stream bytes are ignored
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    function automatic blit_item_t start_item(logic [8:0] x, logic [7:0] row,
                                              logic [7:0] count);
        blit_item_t it;
        it.kind        = KIND_START;
        it.start_x     = x;
        it.start_row   = row;
        it.row_count   = count;
        it.stream_byte = 8'($urandom);
        return it;
    endfunction

    function automatic blit_item_t stream_item(logic [7:0] b);
        blit_item_t it;
        it.kind        = KIND_STREAM;
        it.start_x     = 9'($urandom);
        it.start_row   = 8'($urandom);
        it.row_count   = 8'($urandom);
        it.stream_byte = b;
        return it;
    endfunction

    task automatic add_item(input blit_item_t it);
        item_q.push_back(it);
        stim_count++;
    endtask

    // Literal with a bias toward transparent and half-transparent bytes
    function automatic logic [7:0] pick_literal();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            return 8'h00;
        else if (sel < 30)
            return {4'h0, 4'($urandom_range(1, 15))};
        else if (sel < 45)
            return {4'($urandom_range(1, 15)), 4'h0};
        else
            return 8'($urandom);
    endfunction

    // Emit one encoded row of random pairs, ending with the zero pair
    task automatic add_row();
        int pairs;
        logic [7:0] skip;
        logic [7:0] run;
        pairs = $urandom_range(0, 3);
        // Now and then push the column into saturation with maximal skips
        if ($urandom_range(0, 24) == 0)
        begin
            repeat (9)
            begin
                add_item(stream_item(8'hFF));
                add_item(stream_item(8'h00));
            end
        end
        repeat (pairs)
        begin
            skip = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
            run  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 20))
                                               : 8'($urandom_range(0, 6));
            if (skip == 8'd0 && run == 8'd0)
                run = 8'd1;
            add_item(stream_item(skip));
            add_item(stream_item(run));
            repeat (run) add_item(stream_item(pick_literal()));
        end
        add_item(stream_item(8'h00));
        add_item(stream_item(8'h00));
    endtask

    // Left edge mostly around the visible area, sometimes anywhere in range
    function automatic logic [8:0] pick_x();
        int x;
        if ($urandom_range(0, 3) == 0)
            return 9'($urandom);
        x = $urandom_range(0, 190) - 20;
        return 9'(x);
    endfunction

    task automatic build_directed();
        // Left edge at pixel -4: first two literal columns fall off the left
        add_item(start_item(-9'sd4, 8'd255, 8'd2));
        add_item(stream_item(8'd0));
        add_item(stream_item(8'd4));
        add_item(stream_item(8'hAA));
        add_item(stream_item(8'h55));
        add_item(stream_item(8'hF0));   // column 0, high nibble only
        add_item(stream_item(8'h0F));   // column 1, low nibble only
        // Run across the right edge: transparent, last visible column, clipped
        add_item(stream_item(8'd76));
        add_item(stream_item(8'd3));
        add_item(stream_item(8'h00));
        add_item(stream_item(8'hFF));
        add_item(stream_item(8'h22));
        add_item(stream_item(8'd0));
        add_item(stream_item(8'd0));    // row 255 wraps to row 0
        add_item(stream_item(8'd5));
        add_item(stream_item(8'd0));    // pair with an empty run
        add_item(stream_item(8'd0));
        add_item(stream_item(8'd0));    // last row: done
        add_item(start_item(9'sd255, 8'd0, 8'd0));   // no rows: immediate done
        item_q.push_back(stream_item(8'hFF));        // idle byte, ignored
        // Abort a long sprite partway into a run; left edge at pixel -256
        add_item(start_item(9'h100, 8'd128, 8'd255));
        add_item(stream_item(8'd255));
        add_item(stream_item(8'd2));
        add_item(stream_item(8'h81));
        add_item(start_item(9'd0, 8'd7, 8'd1));
        add_item(stream_item(8'd0));
        add_item(stream_item(8'd0));
    endtask

    task automatic build_random();
        int sel;
        int rows;
        int cut;
        int base;
        while (stim_count < TARGET_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 78)
            begin
                // Well-formed sprite
                rows = $urandom_range(1, 4);
                add_item(start_item(pick_x(), 8'($urandom), 8'(rows)));
                repeat (rows) add_row();
            end
            else if (sel < 90)
            begin
                // Broken sprite: cut the stream short, the next start aborts it
                rows = $urandom_range(1, 255);
                add_item(start_item(pick_x(), 8'($urandom), 8'(rows)));
                base = item_q.size();
                add_row();
                cut = $urandom_range(0, item_q.size() - base);
                repeat (cut) item_q.pop_back();
                stim_count -= cut;
            end
            else if (sel < 95)
            begin
                // Noise, idle unless a broken sprite is still open; harmful only if mishandled
                repeat ($urandom_range(1, 3)) item_q.push_back(stream_item(8'($urandom)));
            end
            else
            begin
                add_item(start_item(9'($urandom), 8'($urandom), 8'd0));
            end
        end
        // Close out whatever the last choice left open
        add_item(start_item(pick_x(), 8'($urandom), 8'd1));
        add_row();
    endtask

    // ------------------------------------------------------------------
    // Driver: hold the beat until accepted, predict on acceptance
    // ------------------------------------------------------------------

    // No idling at all in this window of the run
    function automatic bit calm_window();
        return cycle_count >= 150 && cycle_count < 400;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_sprite_beat(on_bus);
            end
            if (!s_tvalid || s_tready)
            begin
                if (item_q.size() != 0 &&
                    (calm_window() || $urandom_range(0, 99) >= STALL_PCT))
                begin
                    on_bus = item_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_bus.kind;
                    s_tdata  <= {7'b0, on_bus.stream_byte, on_bus.row_count,
                                 on_bus.start_row, on_bus.start_x};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm_window() || $urandom_range(0, 99) >= STALL_PCT;
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest expectation
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_CAP)
            $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (fb_expect_q.size() == 0)
            begin
                report_mismatch("unexpected result beat", m_tdata, 0);
            end
            else
            begin
                want = fb_expect_q.pop_front();
                if (m_tuser[0] !== want.write_valid)
                    report_mismatch("write_valid", m_tuser[0], want.write_valid);
                if (m_tdata[7:0] !== want.out_row)
                    report_mismatch("out_row", m_tdata[7:0], want.out_row);
                if (m_tdata[14:8] !== want.out_column)
                    report_mismatch("out_column", m_tdata[14:8], want.out_column);
                if (m_tdata[22:15] !== want.out_byte)
                    report_mismatch("out_byte", m_tdata[22:15], want.out_byte);
                if (m_tdata[24:23] !== want.nibble_enable)
                    report_mismatch("nibble_enable", m_tdata[24:23], want.nibble_enable);
                if (m_tlast !== want.done_res)
                    report_mismatch("done_res", m_tlast, want.done_res);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither side moves a beat for too long
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_count <= 0;
            end
            else if (quiet_count >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                quiet_count <= quiet_count + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset once, drain, decide
    // ------------------------------------------------------------------

    initial
    begin
        build_directed();
        build_random();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        // Wait for the last beat to go in and every expected result to come out;
        // sample mid-cycle so the driver and monitor updates of this edge are settled
        while (item_q.size() != 0 || s_tvalid || fb_expect_q.size() != 0)
            @(negedge clk);
        // Give a stray extra result the chance to show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fb_expect_q.size() != 0)
            report_mismatch("results left over", fb_expect_q.size(), 0);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
